FILE: hdl/dmad_pkg.sv
// Shared types, codes and the step table function of the delta-modulation decoder.
package dmad_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_SQUELCH = 2'd1,
      OP_DATA    = 2'd2
   } op_type;

   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_1BIT = 2'd1;
   localparam logic [1:0] RES_2BIT = 2'd2;
   localparam logic [1:0] RES_4BIT = 2'd3;

   localparam logic [3:0] CODE_UP_ONE   = 4'd8;
   localparam logic [3:0] CODE_DOWN_ONE = 4'd7;
   localparam logic [3:0] CODE_2BIT_OFS = 4'd6;

   localparam logic [2:0] CSR_ADDR_RUN = 3'd0;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [1:0] res;
      logic [3:0] mult;
   } cmd_type;

   function automatic logic signed [8:0] step_value(logic [3:0] code, logic [3:0] mult);
      logic [4:0] k;
      logic [3:0] mag;
      logic [8:0] prod;
      k    = {1'b0, mult} + 5'd1;
      mag  = code[3] ? (code - 4'd7) : (4'd8 - code);
      prod = {5'b0, mag} * {4'b0, k};
      if (!code[3]) begin
         return -signed'(prod);
      end else if (mult == 4'hF && code == 4'hF) begin
         return 9'sd127;
      end else begin
         return signed'(prod);
      end
   endfunction

endpackage

FILE: hdl/dmad_front.sv
// Front end: takes code bytes, tracks the delta run and queues sample commands.
module dmad_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_code_byte,
   input  logic              req_frame_start,
   input  logic [7:0]        run_samples,
   input  logic              q_full,
   output logic              q_push,
   output dmad_pkg::cmd_type q_cmd
);
   import dmad_pkg::*;

   logic [6:0] left_ff, left_in;
   logic [1:0] res_ff, res_in;
   logic [3:0] mult_ff, mult_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      left_in = left_ff;
      res_in  = res_ff;
      mult_in = mult_ff;
      q_push  = 1'b0;
      q_cmd   = '{op: OP_LOAD, data: req_code_byte, res: res_ff, mult: mult_ff};
      if (accept) begin
         if (req_frame_start) begin
            left_in = '0;
            q_push  = 1'b1;
         end else if (left_ff != '0) begin
            left_in   = left_ff - 7'd1;
            q_cmd.op  = OP_DATA;
            q_push    = (res_ff != RES_NONE);
         end else if (req_code_byte[7]) begin
            q_cmd.data = {req_code_byte[6:0], 1'b0};
            q_push     = 1'b1;
         end else if (req_code_byte[6]) begin
            q_cmd.op = OP_SQUELCH;
            q_push   = (req_code_byte[5:0] != '0);
         end else begin
            mult_in = req_code_byte[3:0];
            res_in  = req_code_byte[5:4];
            unique case (req_code_byte[5:4])
               RES_1BIT: left_in = {2'b0, run_samples[7:3]};
               RES_2BIT: left_in = {1'b0, run_samples[7:2]};
               RES_4BIT: left_in = run_samples[7:1];
               default:  left_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         res_ff  <= '0;
         mult_ff <= '0;
      end else begin
         left_ff <= left_in;
         res_ff  <= res_in;
         mult_ff <= mult_in;
      end
   end

endmodule

FILE: hdl/dmad_queue.sv
// Short command queue between front end and sample generator.
module dmad_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dmad_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output dmad_pkg::cmd_type head_cmd
);
   import dmad_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/dmad_back.sv
// Back end: runs queued commands, one sample per cycle while the output is not stalled, into the output register.
module dmad_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  dmad_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_sample,
   output logic              rsp_last
);
   import dmad_pkg::*;

   cmd_type            cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [5:0]         idx_ff, idx_in;
   logic [7:0]         level_ff, level_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               fire;
   logic               is_last;
   logic [5:0]         n_steps;
   logic [1:0]         pair;
   logic [3:0]         code;
   logic signed [8:0]  delta;
   logic signed [9:0]  sum;
   logic [7:0]         stepped;
   logic [7:0]         sample_new;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = busy_ff && out_free;
   assign is_last  = (idx_ff == n_steps - 6'd1);
   assign q_pop    = q_valid && (!busy_ff || (fire && is_last));

   always_comb begin
      unique case (cur_ff.op)
         OP_SQUELCH: n_steps = cur_ff.data[5:0];
         OP_DATA: begin
            unique case (cur_ff.res)
               RES_1BIT: n_steps = 6'd8;
               RES_2BIT: n_steps = 6'd4;
               default:  n_steps = 6'd2;
            endcase
         end
         default:    n_steps = 6'd1;
      endcase
   end

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    pair = cur_ff.data[7:6];
         2'd1:    pair = cur_ff.data[5:4];
         2'd2:    pair = cur_ff.data[3:2];
         default: pair = cur_ff.data[1:0];
      endcase
      case (cur_ff.res)
         RES_1BIT: code = cur_ff.data[~idx_ff[2:0]] ? CODE_UP_ONE : CODE_DOWN_ONE;
         RES_2BIT: code = {2'b0, pair} + CODE_2BIT_OFS;
         default:  code = idx_ff[0] ? cur_ff.data[3:0] : cur_ff.data[7:4];
      endcase
      delta = step_value(code, cur_ff.mult);
      sum   = signed'({2'b00, level_ff}) + {delta[8], delta};
      if (sum[9]) begin
         stepped = 8'd0;
      end else if (sum[8]) begin
         stepped = 8'hFF;
      end else begin
         stepped = sum[7:0];
      end
      unique case (cur_ff.op)
         OP_LOAD:    sample_new = cur_ff.data;
         OP_SQUELCH: sample_new = level_ff;
         default:    sample_new = stepped;
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (q_pop) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fire && is_last) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 6'd1;
      end
      if (fire) begin
         level_in      = sample_new;
         rsp_valid_in  = 1'b1;
         rsp_sample_in = sample_new;
         rsp_last_in   = is_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: hdl/delta_mod_audio_decoder.sv
// Top level of the delta-modulation speech decoder.
//
// req_ channel: one compressed byte per item, with req_frame_start marking the
// raw initial sample of a frame. rsp_ channel: decoded unsigned 8-bit samples,
// rsp_last high on the final sample caused by an input item.
// APB port: register 0 (byte address 0) holds delta_run_samples; it is read
// when a delta command byte is taken and sets the data byte count of the run.
// A front end classifies each item combinationally and queues a command; the back
// end emits one sample per cycle from its output register while rsp_stall allows.
// When the queue is empty, an item's first sample passes through the queue, the
// back end's command register and its output register. An item yields 8 samples
// for a 1-bit data byte, 4 for 2-bit, 2 for 4-bit, the count for a squelch and 1
// for start or resync; items yielding nothing are not queued. The back end's single
// sample-per-cycle output sets the rate; the queue lets the front end run
// ahead by QUEUE_DEPTH queued commands, after which req_stall rises.
// Reset clears the level, the run state, the register and the queue.
// While rsp_stall is high with an output item valid, the item holds and the back end waits.
module delta_mod_audio_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sample,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dmad_pkg::*;

   logic [7:0] run_samples_ff, run_samples_in;
   logic       q_full;
   logic       q_push;
   cmd_type    push_cmd;
   logic       q_pop;
   logic       head_valid;
   cmd_type    head_cmd;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_ADDR_RUN[2]) ? {24'b0, run_samples_ff} : 32'b0;

   always_comb begin
      run_samples_in = run_samples_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_ADDR_RUN[2]) begin
         run_samples_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_samples_ff <= '0;
      end else begin
         run_samples_ff <= run_samples_in;
      end
   end

   dmad_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_frame_start (req_frame_start),
      .run_samples     (run_samples_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   dmad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   dmad_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last)
   );

endmodule

FILE: hdl/dmad_checker.sv
// Port-level checks for the delta-modulation decoder, bound to the top level.
module dmad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_sample,
   input logic        rsp_last,
   input logic [31:0] prdata,
   input logic        pready
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("stalled output item changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

   a_prdata_upper: assert property (@(posedge clock) disable iff (reset)
      prdata[31:8] == 24'b0)
      else $error("unused register bits read non-zero");

endmodule

bind delta_mod_audio_decoder dmad_checker u_checker (.*);

FILE: dv/tb.sv
// Testbench for the delta-modulation speech decoder: directed and random byte streams, scoreboarded.
`timescale 1ns / 100ps

module tb;
   import dmad_pkg::*;

   localparam logic [7:0] CMD_RESYNC  = 8'h80;
   localparam logic [7:0] CMD_SQUELCH = 8'h40;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] sample;
      logic       last;
   } sample_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_code_byte = 8'd0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_sample;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // decoder state as predicted
   logic [7:0]  cur_level = 8'd0;
   logic [6:0]  bytes_pending = 7'd0;
   logic [1:0]  run_res = RES_NONE;
   logic [3:0]  run_mult = 4'd0;
   logic [7:0]  run_samples_cfg = 8'd0;

   sample_type     pending_samples[$];
   sample_type     want;
   int             errors = 0;
   int             items_sent = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_count = 0;

   delta_mod_audio_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_code_byte(req_code_byte), .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] saturate(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   function automatic int delta_step(logic [3:0] code);
      int k;
      k = int'(run_mult) + 1;
      if (code < CODE_UP_ONE) return -(8 - int'(code)) * k;
      if (k == 16 && code == 4'hF) return 127;
      return (int'(code) - 7) * k;
   endfunction

   function automatic logic [7:0] delta_cmd(logic [1:0] res, logic [3:0] mult);
      return {2'b00, res, mult};
   endfunction

   task automatic predict_samples(input logic [7:0] b, input logic fs);
      logic [7:0] outs[$];
      sample_type s;
      int         k;
      k = int'(run_mult) + 1;
      if (fs) begin
         bytes_pending = 7'd0;
         cur_level = b;
         outs.push_back(cur_level);
      end else if (bytes_pending != 0) begin
         bytes_pending = bytes_pending - 7'd1;
         case (run_res)
            RES_1BIT: begin
               for (int i = 7; i >= 0; i--) begin
                  cur_level = saturate(int'(cur_level) + (b[i] ? k : -k));
                  outs.push_back(cur_level);
               end
            end
            RES_2BIT: begin
               for (int i = 6; i >= 0; i -= 2) begin
                  cur_level = saturate(int'(cur_level)
                                       + delta_step({2'b00, b[i+:2]} + CODE_2BIT_OFS));
                  outs.push_back(cur_level);
               end
            end
            RES_4BIT: begin
               cur_level = saturate(int'(cur_level) + delta_step(b[7:4]));
               outs.push_back(cur_level);
               cur_level = saturate(int'(cur_level) + delta_step(b[3:0]));
               outs.push_back(cur_level);
            end
            default: ;
         endcase
      end else if (b[7]) begin
         cur_level = {b[6:0], 1'b0};
         outs.push_back(cur_level);
      end else if (b[6]) begin
         repeat (b[5:0]) outs.push_back(cur_level);
      end else begin
         run_mult = b[3:0];
         run_res  = b[5:4];
         case (run_res)
            RES_1BIT: bytes_pending = 7'(run_samples_cfg >> 3);
            RES_2BIT: bytes_pending = 7'(run_samples_cfg >> 2);
            RES_4BIT: bytes_pending = 7'(run_samples_cfg >> 1);
            default:  bytes_pending = 7'd0;
         endcase
      end
      foreach (outs[i]) begin
         s.sample = outs[i];
         s.last   = (i == outs.size() - 1);
         pending_samples.push_back(s);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fs);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_code_byte   <= b;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_samples(b, fs);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write then read back; only called with the decoder idle
   task automatic write_run_samples(input logic [7:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_RUN;
      pwdata  <= {24'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      run_samples_cfg = v;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'd0, v}) begin
         errors++;
         $display("%0t run_samples readback: expected %0d, actual %0d", $time, v, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame();
      logic [7:0] b;
      int         left;
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 9))
            0, 1: send_byte(CMD_RESYNC | 8'($urandom_range(0, 127)), 1'b0);
            2, 3: send_byte(CMD_SQUELCH | 8'(($urandom_range(0, 3) == 0)
                            ? $urandom_range(0, 63) : $urandom_range(0, 6)), 1'b0);
            default: begin
               b = delta_cmd(($urandom_range(0, 9) == 0) ? RES_NONE
                             : 2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)));
               send_byte(b, 1'b0);
               left = bytes_pending;
               while (left > 0) begin
                  // occasionally cut the run short; next frame start abandons it
                  if ($urandom_range(0, 39) == 0) return;
                  send_byte(8'($urandom_range(0, 255)), 1'b0);
                  left--;
               end
            end
         endcase
      end
   endtask

   task automatic run_random_frames(input int quota);
      int target;
      target = items_sent + quota;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            send_frame();
         end else begin
            repeat ($urandom_range(1, 5))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end
         if ($urandom_range(0, 15) == 0) pause_until_drained();
      end
   endtask

   task automatic test_before_first_frame();
      send_byte(CMD_SQUELCH | 8'd3, 1'b0);
      send_byte(delta_cmd(RES_1BIT, 4'd15), 1'b0);
      send_byte(CMD_SQUELCH | 8'd1, 1'b0);
      pause_until_drained();
      write_run_samples(8'd8);
      send_byte(delta_cmd(RES_1BIT, 4'd0), 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_commands_and_limits();
      send_byte(8'hFF, 1'b1);
      send_byte(CMD_SQUELCH, 1'b0);
      send_byte(CMD_SQUELCH | 8'h3F, 1'b0);
      send_byte(CMD_RESYNC, 1'b0);
      send_byte(CMD_RESYNC | 8'h7F, 1'b0);
      send_byte(delta_cmd(RES_NONE, 4'd0), 1'b0);
      send_byte(delta_cmd(RES_1BIT, 4'd15), 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(delta_cmd(RES_2BIT, 4'd15), 1'b0);
      send_byte(8'hE4, 1'b0);
      send_byte(8'h1B, 1'b0);
      send_byte(delta_cmd(RES_4BIT, 4'd15), 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
   endtask

   task automatic test_abort_and_mid_run_config();
      pause_until_drained();
      write_run_samples(8'd16);
      send_byte(delta_cmd(RES_1BIT, 4'd1), 1'b0);
      send_byte(8'hF0, 1'b0);
      // new length must not touch the run in progress
      pause_until_drained();
      write_run_samples(8'd0);
      send_byte(8'h0F, 1'b0);
      send_byte(delta_cmd(RES_1BIT, 4'd1), 1'b0);
      pause_until_drained();
      write_run_samples(8'd8);
      send_byte(delta_cmd(RES_4BIT, 4'd5), 1'b0);
      send_byte(8'h9C, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h9C, 1'b0);
   endtask

   task automatic test_random_settings();
      logic [7:0] settings[7];
      settings = '{8'd0, 8'd255, 8'd8, 8'd16, 8'd64, 8'($urandom_range(0, 255)), 8'd7};
      foreach (settings[i]) begin
         pause_until_drained();
         write_run_samples(settings[i]);
         run_random_frames((settings[i] == 8'd255) ? 20 : 45);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_count++;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 6);
         STALL_PERIODIC: rsp_stall <= (stall_count % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            errors++;
            $display("%0t unexpected sample: expected none, actual %0d last %0b",
                     $time, rsp_sample, rsp_last);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               errors++;
               $display("%0t sample: expected %0d, actual %0d", $time, want.sample, rsp_sample);
            end
            if (rsp_last !== want.last) begin
               errors++;
               $display("%0t last: expected %0b, actual %0b", $time, want.last, rsp_last);
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_first_frame();
      test_commands_and_limits();
      test_abort_and_mid_run_config();
      test_random_settings();
      pause_until_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: delta_mod_audio_decoder.f
hdl/dmad_pkg.sv
hdl/dmad_front.sv
hdl/dmad_queue.sv
hdl/dmad_back.sv
hdl/delta_mod_audio_decoder.sv
hdl/dmad_checker.sv
dv/tb.sv
